/* rtl/trs_pkg.sv */
`default_nettype none

package trs_pkg;

    localparam int QW       = 32;
    localparam int COL_W    = 2;
    localparam int DIV_LAT  = QW + 1;
    localparam logic [COL_W-1:0] LAST_COL = 2'd3;

    typedef struct packed {
        logic             op;
        logic [2:0][31:0] pos;
        logic [3:0][31:0] quat;
        logic [2:0][31:0] scl;
        logic [3:0]       negq;
        logic [2:0]       negs;
        logic             zn;
        logic [2:0]       zs;
    } trs_side_t;

    function automatic logic [31:0] sat32(input logic signed [79:0] v);
        logic [31:0] r;
        if (v > 80'sh7FFF_FFFF) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -80'sh8000_0000) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Apply sign to a truncated magnitude quotient and clamp.
    function automatic logic [31:0] div_sat(input logic [31:0] quo, input logic ovf,
                                            input logic neg);
        logic [31:0] r;
        if (neg) begin
            r = (ovf || quo > 32'h8000_0000) ? 32'h8000_0000 : -quo;
        end else begin
            r = (ovf || quo[31]) ? 32'h7FFF_FFFF : quo;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/trs_matrix_builder_unit.sv */
`default_nettype none
// Pipeline: a 33-stage restoring divider (a capture stage, then one quotient
// bit per stage) with arithmetic stages 1..9 around it and an output buffer.
// Inputs stall only while a finished matrix waits on a busy buffer.
// Result side: one column per cycle while m_tready is high.
// Reset: synchronous, active low; clears all valid bits and the column counter.
module trs_matrix_builder_unit #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z, scale_x, scale_y, scale_z
    input  wire logic [319:0]  s_tdata,
    // opcode
    input  wire logic          s_tuser,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // row0, row1, row2, row3
    output logic [127:0]       m_tdata,
    // column_index
    output logic [trs_pkg::COL_W-1:0] m_tuser,
    output logic               m_tlast
);
    import trs_pkg::*;

    localparam int PRW     = 64 - FRAC_BITS;           // shifted 32x32 product
    localparam int TW      = 65 - FRAC_BITS;           // shifted 32x33 product
    localparam int TSW     = TW + 2;                   // sum of three of those
    localparam int EW      = PRW + 3;                  // rotation entry before clamp
    localparam int NW      = PRW + 2;                  // squared norm
    localparam int NUMQ_W  = QW + FRAC_BITS;
    localparam int NUMS_W  = (2 * FRAC_BITS + 1 > QW + 1) ? 2 * FRAC_BITS + 1 : QW + 1;
    localparam logic [NUMS_W-1:0]     NUMS_ONE = NUMS_W'(1) << (2 * FRAC_BITS);
    localparam logic signed [EW-1:0]  ONE_E    = EW'(1) << FRAC_BITS;
    localparam logic [31:0]           ONE_W    = 32'(1) << FRAC_BITS;

    // product slots of the rotation expansion
    localparam int PXX = 0, PYY = 1, PZZ = 2, PXY = 3, PXZ = 4;
    localparam int PYZ = 5, PWX = 6, PWY = 7, PWZ = 8;

    function automatic logic signed [PRW-1:0] fmul(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [63:0] pf;
        pf = a * b;
        return pf[63:FRAC_BITS];
    endfunction

    function automatic logic signed [TW-1:0] fmul_w(input logic signed [31:0] a,
                                                    input logic signed [32:0] b);
        logic signed [64:0] pf;
        pf = a * b;
        return pf[64:FRAC_BITS];
    endfunction

    function automatic logic [31:0] rot_diag(input logic signed [PRW-1:0] a,
                                             input logic signed [PRW-1:0] b);
        logic signed [EW-1:0] e;
        e = ONE_E - ((EW'(a) + EW'(b)) <<< 1);
        return sat32(80'(e));
    endfunction

    function automatic logic [31:0] rot_off(input logic signed [PRW-1:0] a,
                                            input logic signed [PRW-1:0] b,
                                            input logic sub);
        logic signed [EW-1:0] e;
        e = sub ? ((EW'(a) - EW'(b)) <<< 1) : ((EW'(a) + EW'(b)) <<< 1);
        return sat32(80'(e));
    endfunction

    logic adv;

    // ---------------- stage 1: capture the transaction
    logic             v1_reg, op1_reg;
    logic [2:0][31:0] p1_reg, s1_reg;
    logic [3:0][31:0] q1_reg;

    // ---------------- stage 2: quaternion squares
    logic             v2_reg, op2_reg;
    logic [2:0][31:0] p2_reg, s2_reg;
    logic [3:0][31:0] q2_reg;
    logic signed [PRW-1:0] sq2_reg [0:3];

    // ---------------- stage 3: norm and divider operands
    logic             v3_reg, op3_reg;
    logic [2:0][31:0] p3_reg, s3_reg;
    logic [3:0][31:0] q3_reg;
    logic [NW-1:0]    n3_reg;
    logic [NUMQ_W-1:0] numq3_reg [0:3];
    logic [3:0]       negq3_reg;
    logic [31:0]      dens3_reg [0:2];
    logic [2:0]       negs3_reg;

    // ---------------- divider section
    trs_side_t   side_in, side_out;
    logic        dv;
    logic [31:0] qq   [0:3];
    logic        qovf [0:3];
    logic [31:0] sq   [0:2];
    logic        sovf [0:2];

    // ---------------- stages 4..9
    logic             v4_reg, op4_reg;
    logic [2:0][31:0] p4_reg, s4_reg, invs4_reg;
    logic [3:0][31:0] rq4_reg;

    logic             v5_reg, op5_reg;
    logic [2:0][31:0] p5_reg, s5_reg, invs5_reg;
    logic signed [PRW-1:0] pr5_reg [0:8];

    logic             v6_reg, op6_reg;
    logic [2:0][31:0] p6_reg, s6_reg, invs6_reg;
    logic [8:0][31:0] m6_reg;

    logic             v7_reg, op7_reg;
    logic [2:0][31:0] p7_reg, invs7_reg;
    logic [8:0][31:0] ent7_reg;
    logic signed [TW-1:0] tt7_reg [0:8];

    logic             v8_reg, op8_reg;
    logic [2:0][31:0] p8_reg, invs8_reg, t8_reg;
    logic [8:0][31:0] ent8_reg;

    logic             v9_reg, op9_reg;
    logic [2:0][31:0] p9_reg, c9_reg;
    logic [8:0][31:0] ent9_reg;

    // ---------------- output buffer
    logic             ov_reg, ov_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [8:0][31:0] oent_reg;
    logic [2:0][31:0] ocol3_reg;

    // Advance the whole pipe unless a finished matrix waits on a busy buffer.
    assign adv      = !v9_reg || !ov_reg || (m_tready && col_reg == LAST_COL);
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0;
            v4_reg <= 1'b0; v5_reg <= 1'b0; v6_reg <= 1'b0;
            v7_reg <= 1'b0; v8_reg <= 1'b0; v9_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= dv;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
            v9_reg <= v8_reg;
        end
    end

    // stages 1..3
    always_ff @(posedge aclk) begin
        if (adv) begin
            op1_reg <= s_tuser;
            for (int i = 0; i < 3; i++) begin
                p1_reg[i] <= s_tdata[32*i +: 32];
                s1_reg[i] <= s_tdata[32*(i+7) +: 32];
            end
            for (int i = 0; i < 4; i++) begin
                q1_reg[i] <= s_tdata[32*(i+3) +: 32];
            end

            op2_reg <= op1_reg;
            p2_reg  <= p1_reg;
            s2_reg  <= s1_reg;
            q2_reg  <= q1_reg;
            for (int i = 0; i < 4; i++) begin
                sq2_reg[i] <= fmul($signed(q1_reg[i]), $signed(q1_reg[i]));
            end

            op3_reg <= op2_reg;
            p3_reg  <= p2_reg;
            s3_reg  <= s2_reg;
            q3_reg  <= q2_reg;
            n3_reg  <= NW'($unsigned(sq2_reg[0])) + NW'($unsigned(sq2_reg[1]))
                     + NW'($unsigned(sq2_reg[2])) + NW'($unsigned(sq2_reg[3]));
            for (int i = 0; i < 4; i++) begin
                numq3_reg[i] <= {(q2_reg[i][31] ? -q2_reg[i] : q2_reg[i]),
                                 {FRAC_BITS{1'b0}}};
                // w keeps its sign, the vector part is negated
                negq3_reg[i] <= (i == 0) ? q2_reg[i][31] : !q2_reg[i][31];
            end
            for (int i = 0; i < 3; i++) begin
                dens3_reg[i] <= s2_reg[i][31] ? -s2_reg[i] : s2_reg[i];
                negs3_reg[i] <= s2_reg[i][31];
            end
        end
    end

    always_comb begin
        side_in.op   = op3_reg;
        side_in.pos  = p3_reg;
        side_in.quat = q3_reg;
        side_in.scl  = s3_reg;
        side_in.negq = negq3_reg;
        side_in.negs = negs3_reg;
        side_in.zn   = (n3_reg == '0);
        for (int i = 0; i < 3; i++) begin
            side_in.zs[i] = (dens3_reg[i] == '0);
        end
    end

    trs_delay #(
        .WIDTH ($bits(trs_side_t)),
        .DEPTH (DIV_LAT)
    ) u_side (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (v3_reg),
        .in_data   (side_in),
        .out_valid (dv),
        .out_data  (side_out)
    );

    for (genvar i = 0; i < 4; i++) begin : g_qdiv
        trs_div_pipe #(
            .NUM_W (NUMQ_W),
            .DEN_W (NW)
        ) u_div (
            .aclk (aclk),
            .en   (adv),
            .num  (numq3_reg[i]),
            .den  (n3_reg),
            .quo  (qq[i]),
            .ovf  (qovf[i])
        );
    end

    for (genvar i = 0; i < 3; i++) begin : g_sdiv
        trs_div_pipe #(
            .NUM_W (NUMS_W),
            .DEN_W (QW)
        ) u_div (
            .aclk (aclk),
            .en   (adv),
            .num  (NUMS_ONE),
            .den  (dens3_reg[i]),
            .quo  (sq[i]),
            .ovf  (sovf[i])
        );
    end

    // stages 4..9
    always_ff @(posedge aclk) begin
        if (adv) begin
            // stage 4: clamp quotients, pick the rotation source
            op4_reg <= side_out.op;
            p4_reg  <= side_out.pos;
            s4_reg  <= side_out.scl;
            for (int i = 0; i < 4; i++) begin
                rq4_reg[i] <= !side_out.op ? side_out.quat[i] :
                              side_out.zn  ? 32'd0 :
                              div_sat(qq[i], qovf[i], side_out.negq[i]);
            end
            for (int i = 0; i < 3; i++) begin
                invs4_reg[i] <= side_out.zs[i] ? 32'd0 :
                                div_sat(sq[i], sovf[i], side_out.negs[i]);
            end

            // stage 5: nine quaternion products
            op5_reg   <= op4_reg;
            p5_reg    <= p4_reg;
            s5_reg    <= s4_reg;
            invs5_reg <= invs4_reg;
            pr5_reg[PXX] <= fmul($signed(rq4_reg[1]), $signed(rq4_reg[1]));
            pr5_reg[PYY] <= fmul($signed(rq4_reg[2]), $signed(rq4_reg[2]));
            pr5_reg[PZZ] <= fmul($signed(rq4_reg[3]), $signed(rq4_reg[3]));
            pr5_reg[PXY] <= fmul($signed(rq4_reg[1]), $signed(rq4_reg[2]));
            pr5_reg[PXZ] <= fmul($signed(rq4_reg[1]), $signed(rq4_reg[3]));
            pr5_reg[PYZ] <= fmul($signed(rq4_reg[2]), $signed(rq4_reg[3]));
            pr5_reg[PWX] <= fmul($signed(rq4_reg[0]), $signed(rq4_reg[1]));
            pr5_reg[PWY] <= fmul($signed(rq4_reg[0]), $signed(rq4_reg[2]));
            pr5_reg[PWZ] <= fmul($signed(rq4_reg[0]), $signed(rq4_reg[3]));

            // stage 6: rotation entries, index col*3 + row
            op6_reg   <= op5_reg;
            p6_reg    <= p5_reg;
            s6_reg    <= s5_reg;
            invs6_reg <= invs5_reg;
            m6_reg[0] <= rot_diag(pr5_reg[PYY], pr5_reg[PZZ]);
            m6_reg[1] <= rot_off(pr5_reg[PXY], pr5_reg[PWZ], 1'b0);
            m6_reg[2] <= rot_off(pr5_reg[PXZ], pr5_reg[PWY], 1'b1);
            m6_reg[3] <= rot_off(pr5_reg[PXY], pr5_reg[PWZ], 1'b1);
            m6_reg[4] <= rot_diag(pr5_reg[PXX], pr5_reg[PZZ]);
            m6_reg[5] <= rot_off(pr5_reg[PYZ], pr5_reg[PWX], 1'b0);
            m6_reg[6] <= rot_off(pr5_reg[PXZ], pr5_reg[PWY], 1'b0);
            m6_reg[7] <= rot_off(pr5_reg[PYZ], pr5_reg[PWX], 1'b1);
            m6_reg[8] <= rot_diag(pr5_reg[PXX], pr5_reg[PYY]);

            // stage 7: scale the rotation, form translation terms
            op7_reg   <= op6_reg;
            p7_reg    <= p6_reg;
            invs7_reg <= invs6_reg;
            for (int j = 0; j < 3; j++) begin
                for (int i = 0; i < 3; i++) begin
                    ent7_reg[j*3+i] <= sat32(80'(fmul($signed(m6_reg[j*3+i]),
                        $signed(op6_reg ? invs6_reg[i] : s6_reg[j]))));
                    tt7_reg[j*3+i] <= fmul_w($signed(m6_reg[j*3+i]),
                        -33'($signed(p6_reg[j])));
                end
            end

            // stage 8: sum translation terms
            op8_reg   <= op7_reg;
            p8_reg    <= p7_reg;
            invs8_reg <= invs7_reg;
            ent8_reg  <= ent7_reg;
            for (int i = 0; i < 3; i++) begin
                t8_reg[i] <= sat32(80'(TSW'(tt7_reg[i]) + TSW'(tt7_reg[3+i])
                                       + TSW'(tt7_reg[6+i])));
            end

            // stage 9: unscale the translation
            op9_reg  <= op8_reg;
            p9_reg   <= p8_reg;
            ent9_reg <= ent8_reg;
            for (int i = 0; i < 3; i++) begin
                c9_reg[i] <= sat32(80'(fmul($signed(invs8_reg[i]), $signed(t8_reg[i]))));
            end
        end
    end

    // output buffer: hold one matrix, drain it one column per transaction
    always_comb begin
        ov_next  = ov_reg;
        col_next = col_reg;
        if (ov_reg && m_tready) begin
            col_next = col_reg + COL_W'(1);
            if (col_reg == LAST_COL) begin
                ov_next = 1'b0;
            end
        end
        if (adv && v9_reg) begin
            ov_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg  <= 1'b0;
            col_reg <= '0;
        end else begin
            ov_reg  <= ov_next;
            col_reg <= col_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && v9_reg) begin
            oent_reg  <= ent9_reg;
            ocol3_reg <= op9_reg ? c9_reg : p9_reg;
        end
    end

    always_comb begin
        case (col_reg)
            2'd0:    m_tdata = {32'd0, oent_reg[2], oent_reg[1], oent_reg[0]};
            2'd1:    m_tdata = {32'd0, oent_reg[5], oent_reg[4], oent_reg[3]};
            2'd2:    m_tdata = {32'd0, oent_reg[8], oent_reg[7], oent_reg[6]};
            default: m_tdata = {ONE_W, ocol3_reg[2], ocol3_reg[1], ocol3_reg[0]};
        endcase
    end

    assign m_tvalid = ov_reg;
    assign m_tuser  = col_reg;
    assign m_tlast  = (col_reg == LAST_COL);

endmodule

`default_nettype wire

/* rtl/trs_delay.sv */
`default_nettype none

module trs_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    output logic [WIDTH-1:0]      out_data
);

    logic [WIDTH-1:0] data_reg [0:DEPTH-1];
    logic [DEPTH-1:0] vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg[0] <= in_data;
            for (int i = 1; i < DEPTH; i++) begin
                data_reg[i] <= data_reg[i-1];
            end
        end
    end

    assign out_valid = vld_reg[DEPTH-1];
    assign out_data  = data_reg[DEPTH-1];

endmodule

`default_nettype wire

/* rtl/trs_div_pipe.sv */
`default_nettype none

module trs_div_pipe #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 48
) (
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic [31:0]           quo,
    output logic                  ovf
);
    import trs_pkg::*;

    localparam int HI_W = NUM_W - QW;

    logic [DEN_W-1:0] rem_reg [0:QW-1];
    logic [DEN_W-1:0] den_reg [0:QW-1];
    logic [QW-1:0]    lo_reg  [0:QW-1];
    logic [QW-1:0]    quo_reg [0:QW];
    logic             ovf_reg [0:QW];

    // Quotient at or above 2^32 is flagged and clamped later.
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= DEN_W'(num[NUM_W-1:QW]);
            ovf_reg[0] <= (DEN_W'(num[NUM_W-1:QW]) >= den) || (HI_W > DEN_W);
            lo_reg[0]  <= num[QW-1:0];
            den_reg[0] <= den;
            quo_reg[0] <= '0;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_step
        logic [DEN_W:0] trial;
        logic           ge;
        logic [DEN_W:0] diff;
        assign trial = {rem_reg[k-1], lo_reg[k-1][QW-k]};
        assign ge    = trial >= {1'b0, den_reg[k-1]};
        assign diff  = trial - {1'b0, den_reg[k-1]};
        always_ff @(posedge aclk) begin
            if (en) begin
                quo_reg[k] <= {quo_reg[k-1][QW-2:0], ge};
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
        if (k < QW) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                    den_reg[k] <= den_reg[k-1];
                    lo_reg[k]  <= lo_reg[k-1];
                end
            end
        end
    end

    assign quo = quo_reg[QW];
    assign ovf = ovf_reg[QW];

endmodule

`default_nettype wire

/* bench/tb_trs_matrix_builder_unit.sv */
`default_nettype none

module tb_trs_matrix_builder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = 16;
    localparam longint ONE = 64'sd1 << FB;

    // One matrix column as it leaves the block.
    typedef struct {
        logic [1:0]  col;
        logic [31:0] rows [4];
        logic        last;
    } column_t;

    // Column store: predicts four columns per accepted transaction and
    // compares each leaving column with the oldest prediction.
    class column_scoreboard;
        column_t pending [$];
        int      errors;

        function longint sat(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // Exact product then floor shift; operands stay within 33 bits here.
        function longint qmul(longint a, longint b);
            logic signed [127:0] p;
            p = 128'(signed'(a)) * 128'(signed'(b));
            return longint'(p >>> FB);
        endfunction

        function void rotation(longint q [4], output longint m [3][3]);
            longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
            xx = qmul(q[1], q[1]); yy = qmul(q[2], q[2]); zz = qmul(q[3], q[3]);
            xy = qmul(q[1], q[2]); xz = qmul(q[1], q[3]); yz = qmul(q[2], q[3]);
            wx = qmul(q[0], q[1]); wy = qmul(q[0], q[2]); wz = qmul(q[0], q[3]);
            m[0][0] = sat(ONE - 2 * (yy + zz));
            m[0][1] = sat(2 * (xy + wz));
            m[0][2] = sat(2 * (xz - wy));
            m[1][0] = sat(2 * (xy - wz));
            m[1][1] = sat(ONE - 2 * (xx + zz));
            m[1][2] = sat(2 * (yz + wx));
            m[2][0] = sat(2 * (xz + wy));
            m[2][1] = sat(2 * (yz - wx));
            m[2][2] = sat(ONE - 2 * (xx + yy));
        endfunction

        function void note_input(logic op, logic [319:0] d);
            longint p [3], q [4], s [3], qi [4], invs [3], m [3][3], mat [4][4];
            longint n, t;
            column_t c;
            for (int i = 0; i < 3; i++) p[i] = longint'(signed'(d[32*i +: 32]));
            for (int i = 0; i < 4; i++) q[i] = longint'(signed'(d[96 + 32*i +: 32]));
            for (int i = 0; i < 3; i++) s[i] = longint'(signed'(d[224 + 32*i +: 32]));
            if (op == 1'b0) begin
                rotation(q, m);
                for (int j = 0; j < 3; j++) begin
                    for (int i = 0; i < 3; i++) mat[j][i] = sat(qmul(m[j][i], s[j]));
                    mat[j][3] = 0;
                end
                for (int i = 0; i < 3; i++) mat[3][i] = p[i];
            end else begin
                n = 0;
                for (int i = 0; i < 4; i++) n += qmul(q[i], q[i]);
                for (int i = 0; i < 4; i++)
                    qi[i] = (n == 0) ? 0 : sat(((i == 0 ? q[i] : -q[i]) * ONE) / n);
                for (int i = 0; i < 3; i++)
                    invs[i] = (s[i] == 0) ? 0 : sat((ONE * ONE) / s[i]);
                rotation(qi, m);
                for (int j = 0; j < 3; j++) begin
                    for (int i = 0; i < 3; i++) mat[j][i] = sat(qmul(invs[i], m[j][i]));
                    mat[j][3] = 0;
                end
                for (int i = 0; i < 3; i++) begin
                    t = 0;
                    for (int k = 0; k < 3; k++) t += qmul(m[k][i], -p[k]);
                    mat[3][i] = sat(qmul(invs[i], sat(t)));
                end
            end
            mat[3][3] = ONE;
            for (int j = 0; j < 4; j++) begin
                c.col = j[1:0];
                for (int i = 0; i < 4; i++) c.rows[i] = mat[j][i][31:0];
                c.last = (j == 3);
                pending.push_back(c);
            end
        endfunction

        function void check_column(logic [1:0] col, logic [127:0] d, logic last);
            column_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected column %0d", $time, col);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (col !== e.col) begin
                $display("%0t: column_index expected %0d actual %0d", $time, e.col, col);
                errors++;
            end
            if (last !== e.last) begin
                $display("%0t: last_column expected %0d actual %0d", $time, e.last, last);
                errors++;
            end
            for (int i = 0; i < 4; i++)
                if (d[32*i +: 32] !== e.rows[i]) begin
                    $display("%0t: col %0d row%0d expected %h actual %h",
                             $time, e.col, i, e.rows[i], d[32*i +: 32]);
                    errors++;
                end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [319:0] s_tdata = '0;   // pos_x..z, quat_w..z, scale_x..z, from bit 0 up
    logic s_tuser = 1'b0;         // opcode
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [127:0] m_tdata;        // row0, row1, row2, row3
    logic [1:0] m_tuser;          // column_index
    logic m_tlast;

    column_scoreboard board = new();
    bit quiet_phase = 0;   // no idling on either side near the end

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    trs_matrix_builder_unit #(.FRAC_BITS(FB)) dut (.*);

    // Check every column transaction at the rising edge.
    always @(posedge aclk)
        if (aresetn && m_tvalid && m_tready) board.check_column(m_tuser, m_tdata, m_tlast);

    // Result-side backpressure: random stall bursts, none in the quiet phase.
    initial begin
        int burst;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 6);
                m_tready <= 1'b0;
                repeat (burst) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Present one transaction and hold it until accepted; an idle burst may precede it.
    task automatic send_matrix(logic op, logic [319:0] d);
        if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= d;
        do @(posedge aclk); while (!s_tready);
        board.note_input(op, d);
        @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_word(int kind);
        case (kind)
            0: return $urandom();
            1: return 32'(signed'($urandom_range(0, 4 * 65536)) - 2 * 65536);
            2: return 32'h0001_0000;
            3: return '0;
            4: return 32'h7FFF_FFFF;
            5: return 32'h8000_0000;
            default: return 32'(signed'($urandom_range(0, 512)) - 256);
        endcase
    endfunction

    // Build an item from ten words, each drawn from a value class.
    function automatic logic [319:0] make_item(int kind);
        logic [319:0] d;
        for (int i = 0; i < 10; i++)
            d[32*i +: 32] = rand_word(kind < 0 ? $urandom_range(0, 6) : kind);
        return d;
    endfunction

    initial begin
        logic [319:0] d;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, unit and zero quaternions, zero scales, both opcodes.
        for (int op = 0; op < 2; op++) begin
            for (int k = 0; k < 7; k++) send_matrix(op[0], make_item(k));
            d = make_item(1);
            d[96 +: 128] = '0;                       // zero quaternion
            send_matrix(op[0], d);
            d = make_item(2);
            d[256 +: 32] = '0;                       // one zero scale
            d[96 +: 32] = 32'h0001_0000; d[128 +: 96] = '0;
            send_matrix(op[0], d);
            d = make_item(1);
            d[96 +: 128] = {32'h0000_0010, 32'hFFFF_FFF0, 32'h0000_0020, 32'h0000_0001};
            send_matrix(op[0], d);                   // norm floors to zero
            send_matrix(op[0], ~make_item(3));       // all ones
        end

        // Random: mostly mixed words drawn from all value classes, some fully random.
        for (int n = 0; n < 148; n++) begin
            if (n > 120) quiet_phase = 1;
            send_matrix(1'($urandom_range(0, 1)),
                        make_item($urandom_range(0, 3) == 0 ? 0 : -1));
        end
        s_tvalid <= 1'b0;

        fork
            wait (board.pending.size() == 0);
            begin
                repeat (20000) @(posedge aclk);
                $display("tb_trs_matrix_builder_unit failed");
                $finish;
            end
        join_any
        disable fork;
        repeat (60) @(posedge aclk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb_trs_matrix_builder_unit passed");
        else
            $display("tb_trs_matrix_builder_unit failed");
        $finish;
    end

    // Overall watchdog.
    initial begin
        #2ms;
        $display("tb_trs_matrix_builder_unit failed");
        $finish;
    end
endmodule

`default_nettype wire
